[design/dqe_pkg.sv]
`timescale 1ns / 1ps

package dqe_pkg;

  typedef struct packed {
    logic        driver_a;
    logic        driver_b;
    logic        driver_switch;
    logic        passenger_a;
    logic        passenger_b;
    logic        passenger_switch;
    logic [31:0] timestamp;
  } dqe_sample_t;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_DRV_SWITCH = 3'd1;
  localparam logic [2:0] EV_PAS_SWITCH = 3'd2;
  localparam logic [2:0] EV_DRV_CW     = 3'd3;
  localparam logic [2:0] EV_DRV_CCW    = 3'd4;
  localparam logic [2:0] EV_PAS_CW     = 3'd5;
  localparam logic [2:0] EV_PAS_CCW    = 3'd6;

  localparam int STEPS_PER_DETENT = 4;

  localparam logic signed [7:0] DETENT_POS = 8'(STEPS_PER_DETENT);
  localparam logic signed [7:0] DETENT_NEG = -DETENT_POS;
  localparam logic signed [8:0] SUM_MAX    = 9'sd127;
  localparam logic signed [8:0] SUM_MIN    = -9'sd128;

  localparam logic [5:0] LEVELS_RESET = 6'h3F;

  // x4 decode, index is {previous state, current state}
  localparam logic signed [1:0] QUAD_TABLE [16] = '{
    2'sd0,  2'sd1,  -2'sd1, 2'sd0,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    2'sd0,  -2'sd1, 2'sd1,  2'sd0
  };

  // bit 1 set when a is low, bit 0 set when b is low
  function automatic logic [1:0] enc_state(input logic a, input logic b);
    return {~a, ~b};
  endfunction

  function automatic logic signed [7:0] sat_add(input logic signed [7:0] c,
                                                input logic signed [1:0] d);
    logic signed [8:0] s;
    s = {c[7], c} + {{7{d[1]}}, d};
    if (s > SUM_MAX) begin
      return 8'sd127;
    end else if (s < SUM_MIN) begin
      return -8'sd128;
    end
    return s[7:0];
  endfunction

endpackage

[design/dqe_ifs.sv]
`timescale 1ns / 1ps

interface dqe_sample_if;
  logic        valid;
  logic        ready;
  logic        driver_a;
  logic        driver_b;
  logic        driver_switch;
  logic        passenger_a;
  logic        passenger_b;
  logic        passenger_switch;
  logic [31:0] timestamp;

  modport source (
    output valid, driver_a, driver_b, driver_switch,
           passenger_a, passenger_b, passenger_switch, timestamp,
    input  ready
  );
  modport sink (
    input  valid, driver_a, driver_b, driver_switch,
           passenger_a, passenger_b, passenger_switch, timestamp,
    output ready
  );
endinterface

interface dqe_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink (input valid, event_code, output ready);
endinterface

[design/dqe_in_stage.sv]
`timescale 1ns / 1ps

module dqe_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  dqe_pkg::dqe_sample_t in_sample,
  output logic                in_ready,
  input  logic                advance,
  output logic                s1_valid,
  output dqe_pkg::dqe_sample_t s1_sample
);
  import dqe_pkg::*;

  logic        valid_r;
  dqe_sample_t sample_r;

  assign in_ready  = !valid_r || advance;
  assign s1_valid  = valid_r;
  assign s1_sample = sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_sample;
    end
  end

endmodule

[design/dqe_detect.sv]
`timescale 1ns / 1ps

module dqe_detect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  dqe_pkg::dqe_sample_t s1_sample,
  input  logic [31:0]         lockout,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          event_code
);
  import dqe_pkg::*;

  logic [5:0]         prev_r;
  logic signed [7:0]  drv_cnt_r;
  logic signed [7:0]  pas_cnt_r;
  logic [31:0]        last_time_r;
  logic               out_valid_r;
  logic [2:0]         event_r;

  logic [5:0]         levels;
  logic [31:0]        elapsed;
  logic               open_win;
  logic signed [7:0]  drv_sum;
  logic signed [7:0]  pas_sum;
  logic signed [7:0]  drv_cnt_nxt;
  logic signed [7:0]  pas_cnt_nxt;
  logic [31:0]        last_time_nxt;
  logic [2:0]         event_nxt;

  assign advance    = s1_valid && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign event_code = event_r;

  assign levels = {s1_sample.passenger_switch, s1_sample.passenger_b, s1_sample.passenger_a,
                   s1_sample.driver_switch, s1_sample.driver_b, s1_sample.driver_a};
  assign elapsed  = s1_sample.timestamp - last_time_r;
  assign open_win = elapsed > lockout;

  assign drv_sum = sat_add(drv_cnt_r,
    QUAD_TABLE[{enc_state(prev_r[0], prev_r[1]),
                enc_state(s1_sample.driver_a, s1_sample.driver_b)}]);
  assign pas_sum = sat_add(pas_cnt_r,
    QUAD_TABLE[{enc_state(prev_r[3], prev_r[4]),
                enc_state(s1_sample.passenger_a, s1_sample.passenger_b)}]);

  always_comb begin
    event_nxt     = EV_NONE;
    drv_cnt_nxt   = drv_cnt_r;
    pas_cnt_nxt   = pas_cnt_r;
    last_time_nxt = last_time_r;
    if (open_win) begin
      if (prev_r[2] && !s1_sample.driver_switch) begin
        event_nxt = EV_DRV_SWITCH;
      end else if (prev_r[5] && !s1_sample.passenger_switch) begin
        event_nxt = EV_PAS_SWITCH;
      end else begin
        drv_cnt_nxt = drv_sum;
        pas_cnt_nxt = pas_sum;
        if (drv_sum >= DETENT_POS) begin
          drv_cnt_nxt = '0;
          event_nxt   = EV_DRV_CW;
        end else if (drv_sum <= DETENT_NEG) begin
          drv_cnt_nxt = '0;
          event_nxt   = EV_DRV_CCW;
        end else if (pas_sum >= DETENT_POS) begin
          pas_cnt_nxt = '0;
          event_nxt   = EV_PAS_CW;
        end else if (pas_sum <= DETENT_NEG) begin
          pas_cnt_nxt = '0;
          event_nxt   = EV_PAS_CCW;
        end
      end
      if (event_nxt != EV_NONE) begin
        last_time_nxt = s1_sample.timestamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= LEVELS_RESET;
      drv_cnt_r   <= '0;
      pas_cnt_r   <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        prev_r      <= levels;
        drv_cnt_r   <= drv_cnt_nxt;
        pas_cnt_r   <= pas_cnt_nxt;
        last_time_r <= last_time_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_r <= event_nxt;
    end
  end

endmodule

[design/dual_quadrature_encoder_events.sv]
`timescale 1ns / 1ps
// event detector for two rotary encoders with push switches
// in_if: one sample per transfer (a, b and switch levels of both encoders
//   plus a 32-bit timestamp); out_if: one event code per sample
// cfg_we / cfg_wdata: writes the lockout window in ticks; the user must
//   write it only while idle, the block does not enforce this
// a sample passes the input register, then decode and result register
// throughput: one sample per cycle unless out_if stalls; one decode stage
//   reads and updates the counts and last event time in the same cycle
// reset: counts and last event time cleared, previous pin levels all high,
//   lockout zero, no sample or result held
// receiver stall: result register holds its code, an empty input register
//   takes one more sample, then in_if.ready drops until out_if.ready
module dual_quadrature_encoder_events (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  dqe_sample_if.sink  in_if,
  dqe_event_if.source out_if
);
  import dqe_pkg::*;

  logic [31:0] lockout_r;
  dqe_sample_t in_sample;
  dqe_sample_t s1_sample;
  logic        s1_valid;
  logic        advance;

  assign in_sample = '{
    driver_a:         in_if.driver_a,
    driver_b:         in_if.driver_b,
    driver_switch:    in_if.driver_switch,
    passenger_a:      in_if.passenger_a,
    passenger_b:      in_if.passenger_b,
    passenger_switch: in_if.passenger_switch,
    timestamp:        in_if.timestamp
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= '0;
    end else if (cfg_we) begin
      lockout_r <= cfg_wdata;
    end
  end

  dqe_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_sample (in_sample),
    .in_ready  (in_if.ready),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample)
  );

  dqe_detect u_detect (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_sample  (s1_sample),
    .lockout    (lockout_r),
    .advance    (advance),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .event_code (out_if.event_code)
  );

endmodule

[test/tb_dual_quadrature_encoder_events.sv]
`timescale 1ns / 1ps

module tb_dual_quadrature_encoder_events;
  import dqe_pkg::*;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  localparam int QUAD_STEP [16] = '{
    0, 1, -1, 0,
    -1, 0, 0, 1,
    1, 0, 0, -1,
    0, -1, 1, 0
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  dqe_sample_if sample_ch ();
  dqe_event_if  event_ch ();

  dual_quadrature_encoder_events uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (sample_ch),
    .out_if    (event_ch)
  );

  // decoder shadow state
  logic [5:0]        lvl_prev = LEVELS_RESET;
  logic signed [7:0] drv_steps = '0;
  logic signed [7:0] pas_steps = '0;
  logic [31:0]       last_evt_ts = '0;
  logic [31:0]       lockout = '0;

  logic [2:0] pending_codes [$];
  int         mismatches = 0;

  // knob positions and switch levels of the simulated panel
  int          drv_pos = 0;
  int          pas_pos = 0;
  logic        drv_sw = 1'b1;
  logic        pas_sw = 1'b1;
  logic [31:0] ts_now = '0;

  int unsigned burst_left = 0;
  int unsigned tx_gap_max = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  logic        hold_rx = 1'b0;
  int unsigned rx_tick = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic signed [7:0] clamp_add(input logic signed [7:0] c, input int d);
    int v;
    v = int'(c) + d;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return 8'(v);
  endfunction

  // arguments are {b, a}
  function automatic int gray_delta(input logic [1:0] was_ba, input logic [1:0] now_ba);
    logic [3:0] idx;
    idx = {~was_ba[0], ~was_ba[1], ~now_ba[0], ~now_ba[1]};
    return QUAD_STEP[idx];
  endfunction

  function automatic logic [2:0] predict_event(input dqe_sample_t s);
    logic [2:0]  code;
    logic [5:0]  cur;
    logic [31:0] since;
    code = EV_NONE;
    cur = {s.passenger_switch, s.passenger_b, s.passenger_a,
           s.driver_switch, s.driver_b, s.driver_a};
    since = s.timestamp - last_evt_ts;
    if (since > lockout) begin
      if (lvl_prev[2] && !s.driver_switch) begin
        code = EV_DRV_SWITCH;
      end else if (lvl_prev[5] && !s.passenger_switch) begin
        code = EV_PAS_SWITCH;
      end else begin
        drv_steps = clamp_add(drv_steps, gray_delta(lvl_prev[1:0], cur[1:0]));
        pas_steps = clamp_add(pas_steps, gray_delta(lvl_prev[4:3], cur[4:3]));
        if (int'(drv_steps) >= STEPS_PER_DETENT) begin
          drv_steps = '0;
          code = EV_DRV_CW;
        end else if (int'(drv_steps) <= -STEPS_PER_DETENT) begin
          drv_steps = '0;
          code = EV_DRV_CCW;
        end else if (int'(pas_steps) >= STEPS_PER_DETENT) begin
          pas_steps = '0;
          code = EV_PAS_CW;
        end else if (int'(pas_steps) <= -STEPS_PER_DETENT) begin
          pas_steps = '0;
          code = EV_PAS_CCW;
        end
      end
      if (code != EV_NONE) last_evt_ts = s.timestamp;
    end
    lvl_prev = cur;
    return code;
  endfunction

  task automatic report_mismatch(input string what, input logic [2:0] want,
                                 input logic [2:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && event_ch.valid && event_ch.ready) begin
      if (pending_codes.size() == 0) begin
        report_mismatch("unexpected event transfer", 3'bxxx, event_ch.event_code);
      end else if (event_ch.event_code !== pending_codes[0]) begin
        report_mismatch("event code", pending_codes[0], event_ch.event_code);
        void'(pending_codes.pop_front());
      end else begin
        void'(pending_codes.pop_front());
      end
    end
    rx_tick++;
    if (hold_rx) begin
      event_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          event_ch.ready <= 1'b1;
        end
        RX_RANDOM: begin
          event_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          event_ch.ready <= ((rx_tick % 11) < 8);
        end
      endcase
    end
  end

  task automatic send_sample(input dqe_sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    sample_ch.valid            <= 1'b1;
    sample_ch.driver_a         <= s.driver_a;
    sample_ch.driver_b         <= s.driver_b;
    sample_ch.driver_switch    <= s.driver_switch;
    sample_ch.passenger_a      <= s.passenger_a;
    sample_ch.passenger_b      <= s.passenger_b;
    sample_ch.passenger_switch <= s.passenger_switch;
    sample_ch.timestamp        <= s.timestamp;
    do @(posedge clk); while (!sample_ch.ready);
    pending_codes.push_back(predict_event(s));
  endtask

  // turn the knobs by the given steps (2 = both channels flip), set switches, advance time
  task automatic panel_step(input int drv_dir, input int pas_dir, input logic dsw,
                            input logic psw, input logic [31:0] dt);
    dqe_sample_t s;
    drv_pos = (drv_pos + drv_dir + 4) % 4;
    pas_pos = (pas_pos + pas_dir + 4) % 4;
    drv_sw = dsw;
    pas_sw = psw;
    ts_now = ts_now + dt;
    s.driver_a         = (drv_pos < 2);
    s.driver_b         = (drv_pos == 0 || drv_pos == 3);
    s.driver_switch    = drv_sw;
    s.passenger_a      = (pas_pos < 2);
    s.passenger_b      = (pas_pos == 0 || pas_pos == 3);
    s.passenger_switch = pas_sw;
    s.timestamp        = ts_now;
    send_sample(s);
  endtask

  task automatic write_lockout(input logic [31:0] ticks);
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    lockout = ticks;
  endtask

  task automatic test_switch_edges();
    rx_mode = RX_OPEN;
    tx_gap_max = 0;
    panel_step(0, 0, 1'b1, 1'b1, 1);
    panel_step(0, 0, 1'b0, 1'b1, 1);
    panel_step(0, 0, 1'b0, 1'b1, 1);
    panel_step(0, 0, 1'b1, 1'b0, 1);
    panel_step(1, 1, 1'b1, 1'b1, 1);
    panel_step(1, 1, 1'b0, 1'b0, 1);
    // same timestamp as the last event falls inside a zero window
    panel_step(0, 0, 1'b1, 1'b1, 0);
    panel_step(0, 0, 1'b1, 1'b1, 1);
  endtask

  task automatic test_rotation();
    rx_mode = RX_PATTERN;
    tx_gap_max = 2;
    repeat (4) panel_step(1, 0, 1'b1, 1'b1, 1);
    repeat (4) panel_step(-1, 0, 1'b1, 1'b1, 1);
    repeat (4) panel_step(0, -1, 1'b1, 1'b1, 1);
    // both channels change at once
    panel_step(2, 2, 1'b1, 1'b1, 1);
    // both knobs turn together for four steps
    repeat (4) panel_step(1, 1, 1'b1, 1'b1, 1);
    panel_step(0, 0, 1'b1, 1'b1, 1);
  endtask

  task automatic test_lockout_window();
    rx_mode = RX_RANDOM;
    tx_gap_max = 3;
    write_lockout(32'd100);
    panel_step(0, 0, 1'b0, 1'b1, 200);
    panel_step(1, 0, 1'b1, 1'b1, 50);
    panel_step(0, 0, 1'b0, 1'b1, 50);
    panel_step(0, 0, 1'b1, 1'b1, 1);
    // event just before the timestamp wraps
    ts_now = 32'hFFFF_FFC0;
    panel_step(0, 0, 1'b0, 1'b1, 0);
    panel_step(0, 0, 1'b1, 1'b1, 32'h50);
    panel_step(0, 0, 1'b0, 1'b1, 32'h20);
    write_lockout(32'hFFFF_FFFF);
    panel_step(0, 0, 1'b1, 1'b1, 32'h8000_0000);
    panel_step(1, 0, 1'b0, 1'b0, 32'h7FFF_FFFF);
    panel_step(1, 1, 1'b1, 1'b1, 32'h1234_5678);
    write_lockout(32'd0);
  endtask

  task automatic test_random_turns(input int n, input logic [31:0] ticks,
                                   input int unsigned dt_max, input rx_mode_t mode,
                                   input int unsigned gap_max);
    int drv_spin;
    int pas_spin;
    rx_mode = mode;
    tx_gap_max = gap_max;
    write_lockout(ticks);
    drv_spin = 1;
    pas_spin = -1;
    for (int i = 0; i < n; i++) begin
      int   r;
      int   dd;
      int   pd;
      logic dsw;
      logic psw;
      if ($urandom_range(0, 15) == 0) drv_spin = -drv_spin;
      if ($urandom_range(0, 15) == 0) pas_spin = -pas_spin;
      r = $urandom_range(0, 9);
      dd = (r < 6) ? drv_spin : (r < 8) ? 0 : (r == 8) ? -drv_spin : 2;
      r = $urandom_range(0, 9);
      pd = (r < 5) ? pas_spin : (r < 8) ? 0 : (r == 8) ? -pas_spin : 2;
      dsw = ($urandom_range(0, 11) == 0) ? ~drv_sw : drv_sw;
      psw = ($urandom_range(0, 11) == 0) ? ~pas_sw : pas_sw;
      panel_step(dd, pd, dsw, psw, $urandom_range(0, dt_max));
    end
  endtask

  task automatic test_noise(input int n);
    dqe_sample_t s;
    rx_mode = RX_PATTERN;
    tx_gap_max = 5;
    write_lockout($urandom);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) write_lockout($urandom);
      s.driver_a         = $urandom_range(0, 1);
      s.driver_b         = $urandom_range(0, 1);
      s.driver_switch    = $urandom_range(0, 1);
      s.passenger_a      = $urandom_range(0, 1);
      s.passenger_b      = $urandom_range(0, 1);
      s.passenger_switch = $urandom_range(0, 1);
      s.timestamp        = $urandom;
      send_sample(s);
    end
  endtask

  task automatic test_backpressure();
    rx_mode = RX_OPEN;
    tx_gap_max = 0;
    write_lockout(32'd0);
    fork
      begin
        hold_rx <= 1'b1;
        repeat (80) @(posedge clk);
        hold_rx <= 1'b0;
      end
      begin
        for (int i = 0; i < 60; i++) begin
          panel_step(1, -1, ($urandom_range(0, 7) != 0), 1'b1, 1);
        end
      end
    join
  endtask

  initial begin
    rst_n                      = 1'b0;
    cfg_we                     = 1'b0;
    cfg_wdata                  = '0;
    sample_ch.valid            = 1'b0;
    sample_ch.driver_a         = 1'b1;
    sample_ch.driver_b         = 1'b1;
    sample_ch.driver_switch    = 1'b1;
    sample_ch.passenger_a      = 1'b1;
    sample_ch.passenger_b      = 1'b1;
    sample_ch.passenger_switch = 1'b1;
    sample_ch.timestamp        = '0;
    event_ch.ready             = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_switch_edges();
    test_rotation();
    test_lockout_window();
    test_random_turns(350, 32'd0, 2, RX_OPEN, 0);
    test_random_turns(350, 32'd6, 4, RX_RANDOM, 4);
    test_random_turns(250, 32'd40, 30, RX_PATTERN, 6);
    test_backpressure();
    test_noise(250);
    test_random_turns(150, 32'd1, 3, RX_RANDOM, 2);

    sample_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
design/dqe_pkg.sv
design/dqe_ifs.sv
design/dqe_in_stage.sv
design/dqe_detect.sv
design/dual_quadrature_encoder_events.sv
test/tb_dual_quadrature_encoder_events.sv
